// ===== sv/vcdu_pkg.sv =====
// Shared types, codes and constants of the vector clock update block.
package vcdu_pkg;

  localparam int MAX_NODES_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int IDX_IN_W      = 4;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int NODE_ID_W     = 4;
  localparam int NODE_COUNT_W  = 5;

  localparam logic [VAL_W-1:0] SAT_MAX = '1;

  localparam logic [OP_W-1:0] OP_INTERNAL = 2'd0;
  localparam logic [OP_W-1:0] OP_SEND     = 2'd1;
  localparam logic [OP_W-1:0] OP_RECEIVE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;

  typedef enum logic {
    ALU_INC,
    ALU_LT
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [VAL_W-1:0]  a;
    logic [VAL_W-1:0]  b;
  } alu_req_t;

endpackage

// ===== sv/vcdu_if.sv =====
// Valid/ready channel interfaces for the input words and the result words.
interface vcdu_in_if;
  logic                          valid;
  logic                          ready;
  logic [vcdu_pkg::OP_W-1:0]     op;
  logic [vcdu_pkg::IDX_IN_W-1:0] dest;
  logic [vcdu_pkg::IDX_IN_W-1:0] entry_index;
  logic [vcdu_pkg::VAL_W-1:0]    entry_value;
  logic                          first_of_message;

  modport source (output valid, op, dest, entry_index, entry_value, first_of_message,
                  input ready);
  modport sink (input valid, op, dest, entry_index, entry_value, first_of_message,
                output ready);
endinterface

interface vcdu_out_if;
  logic                          valid;
  logic                          ready;
  logic [vcdu_pkg::IDX_IN_W-1:0] out_index;
  logic [vcdu_pkg::VAL_W-1:0]    out_value;
  logic                          is_send_entry;
  logic                          last;

  modport source (output valid, out_index, out_value, is_send_entry, last, input ready);
  modport sink (input valid, out_index, out_value, is_send_entry, last, output ready);
endinterface

// ===== sv/vcdu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vcdu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/vcdu_alu.sv =====
// Shared 32-bit unit: saturating increment and unsigned less-than compare.
module vcdu_alu (
  input  vcdu_pkg::alu_req_t           req,
  output logic [vcdu_pkg::VAL_W-1:0]   result,
  output logic                         flag
);
  import vcdu_pkg::*;

  always_comb begin
    result = req.a;
    flag   = 1'b0;
    case (req.op)
      ALU_INC: begin
        result = (req.a == SAT_MAX) ? req.a : req.a + VAL_W'(1);
      end
      ALU_LT: begin
        flag = (req.a < req.b);
      end
      default: begin
        result = req.a;
        flag   = 1'b0;
      end
    endcase
  end

endmodule

// ===== sv/vector_clock_differential_update.sv =====
// Top level of the differential vector clock of one process.
// The block holds the clock, last-update and last-sent vectors of one process in three
// RAMs and accepts one operation word at a time; in_ch.ready is high only while no
// operation is in progress, and a finished result waits in an output register. An
// internal event passes through S_OWN and S_REPORT; a received entry in use also passes
// through S_MRG_RD and S_MRG. A send scans the n entries in use, reading one entry of
// the clock and last-update RAMs per cycle through the shared compare unit while the
// result channel does not stall. Words with an own index, or for a send a destination,
// at or above the entries in use are dropped without results. The RAMs need no clearing
// pass: per-entry valid bits cleared by reset make unwritten entries read as zero.
module vector_clock_differential_update #(
  parameter int MAX_NODES = vcdu_pkg::MAX_NODES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [vcdu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vcdu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  vcdu_in_if.sink                           in_ch,
  vcdu_out_if.source                        out_ch
);
  import vcdu_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OWN,
    S_MRG_RD,
    S_MRG,
    S_REPORT,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [NODE_ID_W-1:0]    node_id_r, node_id_nxt;
  logic [NODE_COUNT_W-1:0] node_count_r, node_count_nxt;

  logic [OP_W-1:0]         op_r, op_nxt;
  logic [IDX_W-1:0]        dest_r, dest_nxt;
  logic [IDX_W-1:0]        eidx_r, eidx_nxt;
  logic                    eidx_ok_r, eidx_ok_nxt;
  logic [VAL_W-1:0]        eval_r, eval_nxt;
  logic                    first_r, first_nxt;
  logic [VAL_W-1:0]        own_r, own_nxt;
  logic [VAL_W-1:0]        mark_r, mark_nxt;

  logic [CNT_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0]        cmp_idx_r, cmp_idx_nxt;
  logic                    cmp_valid_r, cmp_valid_nxt;
  logic                    pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]        pend_idx_r, pend_idx_nxt;
  logic [VAL_W-1:0]        pend_val_r, pend_val_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_IN_W-1:0]     out_index_r, out_index_nxt;
  logic [VAL_W-1:0]        out_value_r, out_value_nxt;
  logic                    out_send_r, out_send_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [MAX_NODES-1:0]    cv_vld_r, cv_vld_nxt;
  logic [MAX_NODES-1:0]    lu_vld_r, lu_vld_nxt;
  logic [MAX_NODES-1:0]    ls_vld_r, ls_vld_nxt;
  logic                    cv_rvld_r, lu_rvld_r, ls_rvld_r;

  logic                    cv_we, lu_we, ls_we;
  logic [IDX_W-1:0]        cv_waddr, lu_waddr, ls_waddr;
  logic [VAL_W-1:0]        cv_wdata, lu_wdata, ls_wdata;
  logic [IDX_W-1:0]        cv_raddr, lu_raddr, ls_raddr;
  logic [VAL_W-1:0]        cv_rdata, lu_rdata, ls_rdata;
  logic [VAL_W-1:0]        cv_q, lu_q, ls_q;

  alu_req_t                alu_req;
  logic [VAL_W-1:0]        alu_result;
  logic                    alu_flag;

  logic [CNT_W-1:0]        n_act;
  logic [IDX_W-1:0]        node_idx;
  logic                    node_ok, dest_ok, in_eidx_ok;
  logic                    out_take, out_free;
  logic                    tick, hit, stall;
  logic [VAL_W-1:0]        merge_own;

  vcdu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_cv_ram (
    .clk   (clk),
    .we    (cv_we),
    .waddr (cv_waddr),
    .wdata (cv_wdata),
    .raddr (cv_raddr),
    .rdata (cv_rdata)
  );

  vcdu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_lu_ram (
    .clk   (clk),
    .we    (lu_we),
    .waddr (lu_waddr),
    .wdata (lu_wdata),
    .raddr (lu_raddr),
    .rdata (lu_rdata)
  );

  vcdu_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_ls_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  vcdu_alu u_alu (
    .req    (alu_req),
    .result (alu_result),
    .flag   (alu_flag)
  );

  assign n_act = (32'(node_count_r) > 32'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                      : CNT_W'(node_count_r);
  assign node_idx   = IDX_W'(node_id_r);
  assign node_ok    = 32'(node_id_r) < 32'(n_act);
  assign dest_ok    = 32'(in_ch.dest) < 32'(n_act);
  assign in_eidx_ok = 32'(in_ch.entry_index) < 32'(n_act);

  assign cv_q = cv_rvld_r ? cv_rdata : '0;
  assign lu_q = lu_rvld_r ? lu_rdata : '0;
  assign ls_q = ls_rvld_r ? ls_rdata : '0;

  assign out_take = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign tick      = (op_r != OP_RECEIVE) || first_r;
  assign hit       = (state_r == S_SCAN) && cmp_valid_r && alu_flag;
  assign stall     = hit && pend_valid_r && !out_free;
  assign merge_own = (eidx_r == node_idx) ? eval_r : own_r;

  always_comb begin
    cv_raddr = node_idx;
    lu_raddr = stall ? cmp_idx_r : rd_idx_r[IDX_W-1:0];
    ls_raddr = IDX_W'(in_ch.dest);
    case (state_r)
      S_MRG_RD: cv_raddr = eidx_r;
      S_SCAN:   cv_raddr = lu_raddr;
      default:  cv_raddr = node_idx;
    endcase
  end

  always_comb begin
    alu_req = '{op: ALU_INC, a: cv_q, b: '0};
    case (state_r)
      S_MRG:   alu_req = '{op: ALU_LT, a: cv_q, b: eval_r};
      S_SCAN:  alu_req = '{op: ALU_LT, a: mark_r, b: lu_q};
      default: alu_req = '{op: ALU_INC, a: cv_q, b: '0};
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    node_id_nxt    = node_id_r;
    node_count_nxt = node_count_r;
    op_nxt         = op_r;
    dest_nxt       = dest_r;
    eidx_nxt       = eidx_r;
    eidx_ok_nxt    = eidx_ok_r;
    eval_nxt       = eval_r;
    first_nxt      = first_r;
    own_nxt        = own_r;
    mark_nxt       = mark_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_valid_nxt  = cmp_valid_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_index_nxt  = out_index_r;
    out_value_nxt  = out_value_r;
    out_send_nxt   = out_send_r;
    out_last_nxt   = out_last_r;
    cv_we          = 1'b0;
    cv_waddr       = node_idx;
    cv_wdata       = alu_result;
    lu_we          = 1'b0;
    lu_waddr       = node_idx;
    lu_wdata       = alu_result;
    ls_we          = 1'b0;
    ls_waddr       = dest_r;
    ls_wdata       = own_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID:    node_id_nxt    = cfg_wdata[NODE_ID_W-1:0];
        CFG_NODE_COUNT: node_count_nxt = cfg_wdata[NODE_COUNT_W-1:0];
        default:        node_id_nxt    = node_id_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt      = in_ch.op;
          dest_nxt    = IDX_W'(in_ch.dest);
          eidx_nxt    = IDX_W'(in_ch.entry_index);
          eidx_ok_nxt = in_eidx_ok;
          eval_nxt    = in_ch.entry_value;
          first_nxt   = in_ch.first_of_message;
          if (node_ok && ((in_ch.op == OP_INTERNAL) || (in_ch.op == OP_RECEIVE) ||
                          ((in_ch.op == OP_SEND) && dest_ok))) begin
            state_nxt = S_OWN;
          end
        end
      end
      S_OWN: begin
        own_nxt = tick ? alu_result : cv_q;
        cv_we   = tick;
        lu_we   = tick;
        case (op_r)
          OP_INTERNAL: state_nxt = S_REPORT;
          OP_SEND: begin
            mark_nxt       = ls_q;
            rd_idx_nxt     = '0;
            cmp_valid_nxt  = 1'b0;
            pend_valid_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end
          OP_RECEIVE: state_nxt = eidx_ok_r ? S_MRG_RD : S_REPORT;
          default:    state_nxt = S_IDLE;
        endcase
      end
      S_MRG_RD: begin
        state_nxt = S_MRG;
      end
      S_MRG: begin
        if (alu_flag) begin
          cv_we    = 1'b1;
          cv_waddr = eidx_r;
          cv_wdata = eval_r;
          lu_we    = 1'b1;
          lu_waddr = eidx_r;
          lu_wdata = merge_own;
          own_nxt  = merge_own;
        end
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = IDX_IN_W'(node_idx);
          out_value_nxt = own_r;
          out_send_nxt  = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_index_nxt = IDX_IN_W'(pend_idx_r);
              out_value_nxt = pend_val_r;
              out_send_nxt  = 1'b1;
              out_last_nxt  = 1'b0;
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = cmp_idx_r;
            pend_val_nxt   = cv_q;
          end
          if (rd_idx_r < n_act) begin
            cmp_idx_nxt   = rd_idx_r[IDX_W-1:0];
            cmp_valid_nxt = 1'b1;
            rd_idx_nxt    = rd_idx_r + CNT_W'(1);
          end else begin
            cmp_valid_nxt = 1'b0;
            state_nxt     = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_index_nxt = IDX_IN_W'(pend_idx_r);
            out_value_nxt = pend_val_r;
            out_send_nxt  = 1'b1;
            out_last_nxt  = 1'b1;
          end
          pend_valid_nxt = 1'b0;
          ls_we          = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    cv_vld_nxt = cv_vld_r;
    lu_vld_nxt = lu_vld_r;
    ls_vld_nxt = ls_vld_r;
    if (cv_we) begin
      cv_vld_nxt[cv_waddr] = 1'b1;
    end
    if (lu_we) begin
      lu_vld_nxt[lu_waddr] = 1'b1;
    end
    if (ls_we) begin
      ls_vld_nxt[ls_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_id_r    <= '0;
      node_count_r <= NODE_COUNT_W'(16);
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      rd_idx_r     <= '0;
      cv_vld_r     <= '0;
      lu_vld_r     <= '0;
      ls_vld_r     <= '0;
      cv_rvld_r    <= 1'b0;
      lu_rvld_r    <= 1'b0;
      ls_rvld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_id_r    <= node_id_nxt;
      node_count_r <= node_count_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cv_vld_r     <= cv_vld_nxt;
      lu_vld_r     <= lu_vld_nxt;
      ls_vld_r     <= ls_vld_nxt;
      cv_rvld_r    <= cv_vld_r[cv_raddr];
      lu_rvld_r    <= lu_vld_r[lu_raddr];
      ls_rvld_r    <= ls_vld_r[ls_raddr];
    end
    op_r        <= op_nxt;
    dest_r      <= dest_nxt;
    eidx_r      <= eidx_nxt;
    eidx_ok_r   <= eidx_ok_nxt;
    eval_r      <= eval_nxt;
    first_r     <= first_nxt;
    own_r       <= own_nxt;
    mark_r      <= mark_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_val_r  <= pend_val_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_send_r  <= out_send_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_index     = out_index_r;
  assign out_ch.out_value     = out_value_r;
  assign out_ch.is_send_entry = out_send_r;
  assign out_ch.last          = out_last_r;

endmodule

// ===== sv/vcdu_checker.sv =====
// Port-level checks for the vector clock update block and their bind.
module vcdu_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [vcdu_pkg::IDX_IN_W-1:0] out_index,
  input logic [vcdu_pkg::VAL_W-1:0]    out_value,
  input logic                          is_send,
  input logic                          last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_value) &&
                                $stable(is_send) && $stable(last))
    else $error("result word changed while stalled");

  a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !is_send |-> last)
    else $error("own clock report is not the final word");

  a_send_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_send && !last |-> !in_ready)
    else $error("new operation accepted before a send finished");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind vector_clock_differential_update vcdu_checker u_vcdu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_index (out_ch.out_index),
  .out_value (out_ch.out_value),
  .is_send   (out_ch.is_send_entry),
  .last      (out_ch.last)
);
